FILE: rtl/hrf_pkg.sv
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types, constants and helpers for the HTTP request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

  // Defaults
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam logic [31:0] MAX_BODY_RESET  = 32'd1048576;

  // Keyword and blank line lengths
  localparam int unsigned KEY_LEN   = 15;
  localparam int unsigned BLANK_LEN = 4;

  // Character codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPA   = 8'h41;
  localparam logic [7:0] CHAR_UPZ   = 8'h5A;

  // Input command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_SIGN   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } num_phase_e;

  // One result beat
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_body;
    logic        header_done;
    logic        request_end;
    logic [31:0] request_length;
    logic [31:0] body_length;
    logic        length_error;
  } result_t;

  // "content-length:" in lower case, one character per position
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3A; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // ASCII fold to lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CHAR_UPA && c <= CHAR_UPZ) ? c + 8'd32 : c;
  endfunction

endpackage

FILE: rtl/hrf_in_if.sv
// ----------------------------------------------------------------------------
// hrf_in_if
// Input stream channel: one received byte or a connection-close command.
// ----------------------------------------------------------------------------
interface hrf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

FILE: rtl/hrf_out_if.sv
// ----------------------------------------------------------------------------
// hrf_out_if
// Result stream channel: the passed-through byte with its framing tags.
// ----------------------------------------------------------------------------
interface hrf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        in_body;
  logic        header_done;
  logic        request_end;
  logic [31:0] request_length;
  logic [31:0] body_length;
  logic        length_error;

  modport source (output valid, out_byte, in_body, header_done, request_end,
                  request_length, body_length, length_error, input ready);
  modport sink   (input valid, out_byte, in_body, header_done, request_end,
                  request_length, body_length, length_error, output ready);
endinterface

FILE: rtl/hrf_parse.sv
// ----------------------------------------------------------------------------
// hrf_parse
// Framing state and per-byte update: keyword match, length parse,
// blank line detection and body countdown. Result is combinational.
// ----------------------------------------------------------------------------
module hrf_parse import hrf_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic          command_i,
  input  logic [7:0]    data_byte_i,
  input  logic [31:0]   max_body_i,
  output result_t       result_o
);

  // Width used to saturate the byte count to 32 bits
  localparam int unsigned ExtW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 33;

  phase_e                 phase_q, phase_d;
  logic [2:0]             blank_q, blank_d;
  logic [3:0]             key_q, key_d;
  num_phase_e             num_q, num_d;
  logic                   neg_q, neg_d;
  logic [31:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [31:0]            remain_q, remain_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;

  logic [7:0]  lc;
  logic        is_digit;
  logic [35:0] mul10;
  logic [2:0]  blank_nx;
  logic [31:0] len;
  logic        bad;
  logic        rend;
  logic [ExtW-1:0] count_ext;

  // Per-byte update
  always_comb begin
    phase_d  = phase_q;
    blank_d  = blank_q;
    key_d    = key_q;
    num_d    = num_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    remain_d = remain_q;
    count_d  = (count_q == '1) ? count_q : count_q + 1'b1;

    lc       = to_lower(data_byte_i);
    is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
    mul10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
             + {32'd0, data_byte_i[3:0]};
    blank_nx = 3'd0;
    len      = 32'd0;
    bad      = 1'b0;
    rend     = 1'b0;

    result_o              = '0;
    result_o.out_byte     = data_byte_i;

    if (phase_q == PH_HEADER) begin
      // Keyword match, then the number after it
      if (key_q == 4'(KEY_LEN)) begin
        if (num_q == NUM_SKIP &&
            (data_byte_i == CHAR_SPACE || data_byte_i == CHAR_TAB)) begin
          num_d = num_q;
        end else if (num_q == NUM_SKIP &&
                     (data_byte_i == CHAR_PLUS || data_byte_i == CHAR_MINUS)) begin
          neg_d = (data_byte_i == CHAR_MINUS);
          num_d = NUM_SIGN;
        end else if (num_q != NUM_DONE && is_digit) begin
          if (mul10[35:32] != 4'd0) begin
            ovf_d = 1'b1;
            acc_d = '1;
          end else begin
            acc_d = mul10[31:0];
          end
          num_d = NUM_DIGITS;
        end else begin
          num_d = NUM_DONE;
        end
      end else if (lc == key_char(key_q)) begin
        key_d = key_q + 4'd1;
      end else begin
        key_d = (lc == key_char(4'd0)) ? 4'd1 : 4'd0;
      end

      // CR LF CR LF tracking
      if (data_byte_i == CHAR_CR) begin
        blank_nx = (blank_q == 3'd2) ? 3'd3 : 3'd1;
      end else if (data_byte_i == CHAR_LF && (blank_q == 3'd1 || blank_q == 3'd3)) begin
        blank_nx = blank_q + 3'd1;
      end else begin
        blank_nx = 3'd0;
      end
      blank_d = blank_nx;

      // End of header: check and latch the body length
      if (blank_nx == 3'(BLANK_LEN)) begin
        bad = ovf_d || (neg_d && acc_d != 32'd0) || (acc_d > max_body_i);
        len = bad ? 32'd0 : acc_d;
        result_o.header_done  = 1'b1;
        result_o.length_error = bad;
        result_o.body_length  = len;
        acc_d   = len;
        blank_d = 3'd0;
        if (len == 32'd0) begin
          rend = 1'b1;
        end else begin
          phase_d  = PH_BODY;
          remain_d = len;
        end
      end
    end else begin
      // Body countdown
      result_o.in_body     = 1'b1;
      result_o.body_length = acc_q;
      if (remain_q != 32'd0) begin
        remain_d = remain_q - 32'd1;
      end
      if (remain_d == 32'd0) begin
        rend = 1'b1;
      end
    end

    result_o.request_end    = rend;
    count_ext               = ExtW'(count_d);
    result_o.request_length = (count_ext > ExtW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                : count_ext[31:0];
  end

  // Framing state; close command or request end returns to reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      blank_q  <= 3'd0;
      key_q    <= 4'd0;
      num_q    <= NUM_SKIP;
      neg_q    <= 1'b0;
      acc_q    <= 32'd0;
      ovf_q    <= 1'b0;
      remain_q <= 32'd0;
      count_q  <= '0;
    end else if (beat_i) begin
      if (command_i == CMD_CLOSE || rend) begin
        phase_q  <= PH_HEADER;
        blank_q  <= 3'd0;
        key_q    <= 4'd0;
        num_q    <= NUM_SKIP;
        neg_q    <= 1'b0;
        acc_q    <= 32'd0;
        ovf_q    <= 1'b0;
        remain_q <= 32'd0;
        count_q  <= '0;
      end else begin
        phase_q  <= phase_d;
        blank_q  <= blank_d;
        key_q    <= key_d;
        num_q    <= num_d;
        neg_q    <= neg_d;
        acc_q    <= acc_d;
        ovf_q    <= ovf_d;
        remain_q <= remain_d;
        count_q  <= count_d;
      end
    end
  end

endmodule

FILE: rtl/http_request_framer_core.sv
// ----------------------------------------------------------------------------
// http_request_framer_core
// Marks header, body and request boundaries in a received HTTP byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_in carries one beat per received byte (command = 0) or a
//   connection-close (command = 1), which drops the partial request and
//   produces no result beat. res_out carries one beat per byte: the byte,
//   header/body tag, header_done, request_end, running request length,
//   body length and the length error flag.
//   Each accepted byte's result is registered and shows on res_out in the
//   cycle after. Throughput is one byte per cycle while res_out is ready;
//   the framing state is a single register stage updated by each beat.
//   When res_out is stalled the result register holds its beat and req_in
//   deasserts ready; as soon as res_out takes the beat a new byte is taken
//   in the same cycle.
//   cfg_we_i / cfg_wdata_i write max_body_length; write only while idle.
//   Reset clears the framing state and the result valid, and restores
//   max_body_length to 1048576.
// ----------------------------------------------------------------------------
module http_request_framer_core import hrf_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrf_in_if.sink      req_in,
  hrf_out_if.source   res_out,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] max_body_q;
  logic        out_valid_q, out_valid_d;
  result_t     res_q;
  result_t     res_c;
  logic        beat;

  // Accept whenever the result register is empty or being drained
  assign req_in.ready = !out_valid_q || res_out.ready;
  assign beat         = req_in.valid && req_in.ready;

  hrf_parse #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .command_i   (req_in.command),
    .data_byte_i (req_in.data_byte),
    .max_body_i  (max_body_q),
    .result_o    (res_c)
  );

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MAX_BODY_RESET;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (beat && req_in.command == CMD_BYTE) begin
      out_valid_d = 1'b1;
    end else if (res_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (beat && req_in.command == CMD_BYTE) begin
      res_q <= res_c;
    end
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.out_byte       = res_q.out_byte;
  assign res_out.in_body        = res_q.in_body;
  assign res_out.header_done    = res_q.header_done;
  assign res_out.request_end    = res_q.request_end;
  assign res_out.request_length = res_q.request_length;
  assign res_out.body_length    = res_q.body_length;
  assign res_out.length_error   = res_q.length_error;

endmodule
